// File: rtl/core/cmcd_pkg.sv
package cmcd_pkg;

  localparam int ROW_LENGTH_DEFAULT  = 16;
  localparam int HOME_LENGTH_DEFAULT = 3;

  // action codes of an input word
  localparam logic [1:0] ACT_RX   = 2'd0;
  localparam logic [1:0] ACT_TX   = 2'd1;
  localparam logic [1:0] ACT_CELL = 2'd2;

  // command letters, lower case
  localparam logic [7:0] CMD_PAUSE   = 8'h70;  // p
  localparam logic [7:0] CMD_RESTART = 8'h69;  // i
  localparam logic [7:0] CMD_CONT    = 8'h63;  // c
  localparam logic [7:0] CMD_MORE    = 8'h6d;  // m
  localparam logic [7:0] CMD_LESS    = 8'h64;  // d

  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [7:0]  LINE_FEED       = 8'h0a;
  localparam logic [7:0]  CARRIAGE_RETURN = 8'h0d;
  localparam logic [7:0]  SPACE_CHAR      = 8'h20;
  localparam logic [15:0] DUTY_STEP       = 16'd10;

  // register reset values
  localparam logic [7:0]  HOME_FIRST_RESET   = 8'd27;
  localparam logic [7:0]  HOME_SECOND_RESET  = 8'd91;
  localparam logic [7:0]  HOME_THIRD_RESET   = 8'd72;
  localparam logic [15:0] DUTY_CEILING_RESET = 16'd65535;
  localparam logic [15:0] DUTY_FLOOR_RESET   = 16'd0;
  localparam logic [15:0] DUTY_START_RESET   = 16'd0;

  // register indexes (byte address / 4)
  localparam int          REG_ADDR_W       = 5;
  localparam logic [2:0]  REG_HOME_FIRST   = 3'd0;
  localparam logic [2:0]  REG_HOME_SECOND  = 3'd1;
  localparam logic [2:0]  REG_HOME_THIRD   = 3'd2;
  localparam logic [2:0]  REG_DUTY_CEILING = 3'd3;
  localparam logic [2:0]  REG_DUTY_FLOOR   = 3'd4;
  localparam logic [2:0]  REG_DUTY_START   = 3'd5;

  typedef enum logic [2:0] {
    PH_HOME = 3'd0,
    PH_ROW0 = 3'd1,
    PH_LF   = 3'd2,
    PH_CR   = 3'd3,
    PH_ROW1 = 3'd4
  } frame_phase_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_CONST = 2'd1,
    SRC_CELL  = 2'd2
  } byte_src_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       cell_row;
    logic [3:0] cell_col;
    logic [7:0] cell_char;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        timer_running;
    logic        timer_restart;
    logic [15:0] duty_value;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  home_first;
    logic [7:0]  home_second;
    logic [7:0]  home_third;
    logic [15:0] duty_ceiling;
    logic [15:0] duty_floor;
    logic [15:0] duty_start;
    logic        duty_load;
  } cfg_regs_t;

  typedef struct packed {
    byte_src_t   src;
    logic [7:0]  const_byte;
    logic        running;
    logic        restart;
    logic [15:0] duty;
  } step_t;

endpackage

// File: rtl/core/cmcd_ram.sv
module cmcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/cmcd_cfg.sv
module cmcd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmcd_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output cmcd_pkg::cfg_regs_t             cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.home_first   <= cmcd_pkg::HOME_FIRST_RESET;
      cfg.home_second  <= cmcd_pkg::HOME_SECOND_RESET;
      cfg.home_third   <= cmcd_pkg::HOME_THIRD_RESET;
      cfg.duty_ceiling <= cmcd_pkg::DUTY_CEILING_RESET;
      cfg.duty_floor   <= cmcd_pkg::DUTY_FLOOR_RESET;
      cfg.duty_start   <= cmcd_pkg::DUTY_START_RESET;
      cfg.duty_load    <= 1'b0;
    end else begin
      // duty_load is a one-cycle strobe that reloads the duty value
      cfg.duty_load <= 1'b0;
      if (wr) begin
        unique case (idx)
          cmcd_pkg::REG_HOME_FIRST:   cfg.home_first   <= pwdata[7:0];
          cmcd_pkg::REG_HOME_SECOND:  cfg.home_second  <= pwdata[7:0];
          cmcd_pkg::REG_HOME_THIRD:   cfg.home_third   <= pwdata[7:0];
          cmcd_pkg::REG_DUTY_CEILING: cfg.duty_ceiling <= pwdata[15:0];
          cmcd_pkg::REG_DUTY_FLOOR:   cfg.duty_floor   <= pwdata[15:0];
          cmcd_pkg::REG_DUTY_START: begin
            cfg.duty_start <= pwdata[15:0];
            cfg.duty_load  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      cmcd_pkg::REG_HOME_FIRST:   prdata = {24'd0, cfg.home_first};
      cmcd_pkg::REG_HOME_SECOND:  prdata = {24'd0, cfg.home_second};
      cmcd_pkg::REG_HOME_THIRD:   prdata = {24'd0, cfg.home_third};
      cmcd_pkg::REG_DUTY_CEILING: prdata = {16'd0, cfg.duty_ceiling};
      cmcd_pkg::REG_DUTY_FLOOR:   prdata = {16'd0, cfg.duty_floor};
      cmcd_pkg::REG_DUTY_START:   prdata = {16'd0, cfg.duty_start};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/core/cmcd_cmd.sv
module cmcd_cmd #(
  parameter int ROW_LENGTH  = cmcd_pkg::ROW_LENGTH_DEFAULT,
  parameter int HOME_LENGTH = cmcd_pkg::HOME_LENGTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  cmcd_pkg::in_item_t  item,
  input  cmcd_pkg::cfg_regs_t cfg,
  output cmcd_pkg::step_t     step,
  output logic                wr_en,
  output logic [$clog2(ROW_LENGTH):0] wr_addr,
  output logic [7:0]          wr_data,
  output logic [$clog2(ROW_LENGTH):0] rd_addr,
  output logic                rd_cell_valid
);

  localparam int COL_W  = $clog2(ROW_LENGTH);
  localparam int DEPTH  = 2 << COL_W;
  localparam int IDX_W  = (COL_W > 2) ? COL_W : 2;
  localparam int CMP_W  = ((COL_W > 4) ? COL_W : 4) + 2;

  cmcd_pkg::frame_phase_t phase, phase_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic [15:0]            duty, duty_next, duty_cur;
  logic                   running, running_next;
  logic [DEPTH-1:0]       cell_valid;

  logic [7:0]       lc;
  logic             up_ok, down_ok, restart, rd_row;
  logic [CMP_W-1:0] col_ext;
  logic             idx_row_last, idx_home_last;
  logic [7:0]       home_byte;

  assign lc = (item.rx_byte >= cmcd_pkg::UPPER_A && item.rx_byte <= cmcd_pkg::UPPER_Z)
              ? item.rx_byte + cmcd_pkg::CASE_OFFSET : item.rx_byte;

  // a duty_start write takes effect for the word accepted with the reload
  assign duty_cur = cfg.duty_load ? cfg.duty_start : duty;

  assign up_ok   = ({1'b0, duty_cur} + {1'b0, cmcd_pkg::DUTY_STEP}) < {1'b0, cfg.duty_ceiling};
  assign down_ok = {1'b0, duty_cur} > ({1'b0, cfg.duty_floor} + {1'b0, cmcd_pkg::DUTY_STEP});

  assign idx_row_last  = idx == IDX_W'(ROW_LENGTH - 1);
  assign idx_home_last = idx == IDX_W'(HOME_LENGTH - 1);

  always_comb begin
    if (idx == IDX_W'(0)) begin
      home_byte = cfg.home_first;
    end else if (idx == IDX_W'(1)) begin
      home_byte = cfg.home_second;
    end else begin
      home_byte = cfg.home_third;
    end
  end

  // command decode and duty/run update
  always_comb begin
    duty_next    = duty_cur;
    running_next = running;
    restart      = 1'b0;
    if (item.action == cmcd_pkg::ACT_RX) begin
      case (lc)
        cmcd_pkg::CMD_PAUSE:   running_next = 1'b0;
        cmcd_pkg::CMD_RESTART: restart      = 1'b1;
        cmcd_pkg::CMD_CONT:    running_next = 1'b1;
        cmcd_pkg::CMD_MORE: begin
          if (up_ok) duty_next = duty_cur + cmcd_pkg::DUTY_STEP;
        end
        cmcd_pkg::CMD_LESS: begin
          if (down_ok) duty_next = duty_cur - cmcd_pkg::DUTY_STEP;
        end
        default: ;
      endcase
    end
  end

  // frame sequencer
  always_comb begin
    phase_next      = phase;
    idx_next        = idx;
    step.src        = cmcd_pkg::SRC_NONE;
    step.const_byte = 8'd0;
    step.running    = running_next;
    step.restart    = restart;
    step.duty       = duty_next;
    rd_row          = 1'b0;
    if (item.action == cmcd_pkg::ACT_TX) begin
      unique case (phase)
        cmcd_pkg::PH_HOME: begin
          step.src        = cmcd_pkg::SRC_CONST;
          step.const_byte = home_byte;
          idx_next        = idx_home_last ? IDX_W'(0) : idx + IDX_W'(1);
          if (idx_home_last) phase_next = cmcd_pkg::PH_ROW0;
        end
        cmcd_pkg::PH_ROW0: begin
          step.src = cmcd_pkg::SRC_CELL;
          idx_next = idx_row_last ? IDX_W'(0) : idx + IDX_W'(1);
          if (idx_row_last) phase_next = cmcd_pkg::PH_LF;
        end
        cmcd_pkg::PH_LF: begin
          step.src        = cmcd_pkg::SRC_CONST;
          step.const_byte = cmcd_pkg::LINE_FEED;
          phase_next      = cmcd_pkg::PH_CR;
        end
        cmcd_pkg::PH_CR: begin
          step.src        = cmcd_pkg::SRC_CONST;
          step.const_byte = cmcd_pkg::CARRIAGE_RETURN;
          phase_next      = cmcd_pkg::PH_ROW1;
        end
        cmcd_pkg::PH_ROW1: begin
          step.src = cmcd_pkg::SRC_CELL;
          rd_row   = 1'b1;
          idx_next = idx_row_last ? IDX_W'(0) : idx + IDX_W'(1);
          if (idx_row_last) phase_next = cmcd_pkg::PH_HOME;
        end
        default: phase_next = cmcd_pkg::PH_HOME;
      endcase
    end
  end

  // window writes: echo of a received byte, or a cell write inside the row
  assign col_ext = CMP_W'(item.cell_col);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {1'b1, COL_W'(ROW_LENGTH - 1)};
    wr_data = item.rx_byte;
    if (accept && item.action == cmcd_pkg::ACT_RX) begin
      wr_en = 1'b1;
    end else if (accept && item.action == cmcd_pkg::ACT_CELL &&
                 col_ext < CMP_W'(ROW_LENGTH)) begin
      wr_en   = 1'b1;
      wr_addr = {item.cell_row, col_ext[COL_W-1:0]};
      wr_data = item.cell_char;
    end
  end

  assign rd_addr       = {rd_row, idx[COL_W-1:0]};
  assign rd_cell_valid = cell_valid[rd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= cmcd_pkg::PH_HOME;
      idx        <= '0;
      duty       <= cmcd_pkg::DUTY_START_RESET;
      running    <= 1'b0;
      cell_valid <= '0;
    end else begin
      if (accept) begin
        duty <= duty_next;
      end else if (cfg.duty_load) begin
        duty <= cfg.duty_start;
      end
      if (accept) begin
        phase   <= phase_next;
        idx     <= idx_next;
        running <= running_next;
      end
      // a cell never written reads as a space
      if (wr_en) begin
        cell_valid[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/console_mirror_and_command_decoder_unit.sv
// Console mirror and command decoder. Each input word is a received command
// byte, a transmitter-ready event or a window cell write; every accepted word
// gives exactly one result word with the frame byte (if any), the timer run
// flag, the restart pulse and the duty value. One word is accepted per clock
// cycle unless in_stall holds it while the output register is stalled; a
// result is presented after its word has passed the input stage, loaded with
// the registered read of the window RAM at the accept, and then the output
// register. The window reads as spaces after reset with no clearing pass, so
// words are accepted from the first cycle after reset.
module console_mirror_and_command_decoder_unit #(
  parameter int ROW_LENGTH  = cmcd_pkg::ROW_LENGTH_DEFAULT,
  parameter int HOME_LENGTH = cmcd_pkg::HOME_LENGTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cmcd_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cmcd_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmcd_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int ADDR_W = $clog2(ROW_LENGTH) + 1;
  localparam int DEPTH  = 2 << $clog2(ROW_LENGTH);

  cmcd_pkg::cfg_regs_t cfg;
  cmcd_pkg::step_t     step, s1_step;
  logic                accept, advance, s1_valid, s1_cell_valid;
  logic                wr_en, rd_cell_valid;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  logic [7:0]          wr_data, rd_data;
  cmcd_pkg::out_item_t result;

  cmcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cmcd_cmd #(
    .ROW_LENGTH  (ROW_LENGTH),
    .HOME_LENGTH (HOME_LENGTH)
  ) u_cmd (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (in_data),
    .cfg           (cfg),
    .step          (step),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .rd_cell_valid (rd_cell_valid)
  );

  // read is launched with the accept and held while the word waits
  cmcd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    result.tx_valid      = s1_step.src != cmcd_pkg::SRC_NONE;
    result.timer_running = s1_step.running;
    result.timer_restart = s1_step.restart;
    result.duty_value    = s1_step.duty;
    case (s1_step.src)
      cmcd_pkg::SRC_CONST: result.tx_byte = s1_step.const_byte;
      cmcd_pkg::SRC_CELL:  result.tx_byte = s1_cell_valid ? rd_data : cmcd_pkg::SPACE_CHAR;
      default:             result.tx_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step       <= step;
      s1_cell_valid <= rd_cell_valid;
    end
    if (advance && s1_valid) begin
      out_data <= result;
    end
  end

endmodule

// File: bench/console_mirror_and_command_decoder_unit_test.sv
`timescale 1ns / 100ps

module console_mirror_and_command_decoder_unit_test;

  localparam logic [1:0] ACT_NONE = 2'd3;  // unused action code
  localparam int ROW_LEN = cmcd_pkg::ROW_LENGTH_DEFAULT;
  localparam int HOME_LEN = cmcd_pkg::HOME_LENGTH_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int IN_W = $bits(cmcd_pkg::in_item_t);

  class console_mirror_board;
    logic [7:0]             window [2][ROW_LEN];
    cmcd_pkg::frame_phase_t phase;
    int                     pos;
    logic [15:0]            duty;
    logic                   running;
    logic [7:0]             home [HOME_LEN];
    logic [15:0]            ceiling;
    logic [15:0]            floor_level;
    cmcd_pkg::out_item_t    expected_words [$];
    int unsigned            errors;
    int unsigned            words_checked;
    int unsigned            frame_bytes;
    int unsigned            duty_moves;
    int unsigned            duty_blocked;

    function new();
      foreach (window[r, c]) window[r][c] = cmcd_pkg::SPACE_CHAR;
      phase = cmcd_pkg::PH_HOME;
      pos = 0;
      duty = cmcd_pkg::DUTY_START_RESET;
      running = 1'b0;
      home[0] = cmcd_pkg::HOME_FIRST_RESET;
      home[1] = cmcd_pkg::HOME_SECOND_RESET;
      home[2] = cmcd_pkg::HOME_THIRD_RESET;
      ceiling = cmcd_pkg::DUTY_CEILING_RESET;
      floor_level = cmcd_pkg::DUTY_FLOOR_RESET;
    endfunction

    function void configure(logic [2:0] idx, logic [31:0] value);
      case (idx)
        cmcd_pkg::REG_HOME_FIRST:   home[0] = value[7:0];
        cmcd_pkg::REG_HOME_SECOND:  home[1] = value[7:0];
        cmcd_pkg::REG_HOME_THIRD:   home[2] = value[7:0];
        cmcd_pkg::REG_DUTY_CEILING: ceiling = value[15:0];
        cmcd_pkg::REG_DUTY_FLOOR:   floor_level = value[15:0];
        cmcd_pkg::REG_DUTY_START:   duty = value[15:0];  // reload at once
        default: ;
      endcase
    endfunction

    function logic [7:0] next_frame_byte();
      logic [7:0] b;
      case (phase)
        cmcd_pkg::PH_HOME: begin
          b = home[pos];
          pos++;
          if (pos >= HOME_LEN) begin
            phase = cmcd_pkg::PH_ROW0;
            pos = 0;
          end
        end
        cmcd_pkg::PH_ROW0: begin
          b = window[0][pos];
          pos++;
          if (pos >= ROW_LEN) begin
            phase = cmcd_pkg::PH_LF;
            pos = 0;
          end
        end
        cmcd_pkg::PH_LF: begin
          b = cmcd_pkg::LINE_FEED;
          phase = cmcd_pkg::PH_CR;
        end
        cmcd_pkg::PH_CR: begin
          b = cmcd_pkg::CARRIAGE_RETURN;
          phase = cmcd_pkg::PH_ROW1;
        end
        default: begin
          b = window[1][pos];
          pos++;
          if (pos >= ROW_LEN) begin
            phase = cmcd_pkg::PH_HOME;
            pos = 0;
          end
        end
      endcase
      return b;
    endfunction

    function cmcd_pkg::out_item_t console_step(cmcd_pkg::in_item_t w);
      cmcd_pkg::out_item_t r;
      logic [7:0]          lc;
      r = '0;
      case (w.action)
        cmcd_pkg::ACT_RX: begin
          lc = (w.rx_byte >= cmcd_pkg::UPPER_A && w.rx_byte <= cmcd_pkg::UPPER_Z) ?
               w.rx_byte + cmcd_pkg::CASE_OFFSET : w.rx_byte;
          if (lc == cmcd_pkg::CMD_PAUSE) running = 1'b0;
          else if (lc == cmcd_pkg::CMD_RESTART) r.timer_restart = 1'b1;
          else if (lc == cmcd_pkg::CMD_CONT) running = 1'b1;
          else if (lc == cmcd_pkg::CMD_MORE) begin
            if (int'(duty) + int'(cmcd_pkg::DUTY_STEP) < int'(ceiling)) begin
              duty = duty + cmcd_pkg::DUTY_STEP;
              duty_moves++;
            end else duty_blocked++;
          end else if (lc == cmcd_pkg::CMD_LESS) begin
            if (int'(duty) - int'(cmcd_pkg::DUTY_STEP) > int'(floor_level)) begin
              duty = duty - cmcd_pkg::DUTY_STEP;
              duty_moves++;
            end else duty_blocked++;
          end
          window[1][ROW_LEN-1] = w.rx_byte;  // echo cell
        end
        cmcd_pkg::ACT_TX: begin
          r.tx_byte = next_frame_byte();
          r.tx_valid = 1'b1;
          frame_bytes++;
        end
        cmcd_pkg::ACT_CELL: begin
          if (int'(w.cell_col) < ROW_LEN) window[w.cell_row][w.cell_col] = w.cell_char;
        end
        default: ;
      endcase
      r.timer_running = running;
      r.duty_value = duty;
      return r;
    endfunction

    function void accept_word(cmcd_pkg::in_item_t w);
      expected_words.push_back(console_step(w));
    endfunction

    function void check_word(cmcd_pkg::out_item_t got);
      cmcd_pkg::out_item_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got.tx_valid !== want.tx_valid) begin
        $error("tx_valid: expected %0d, got %0d", want.tx_valid, got.tx_valid);
        errors++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %0d, got %0d", want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.timer_running !== want.timer_running) begin
        $error("timer_running: expected %0d, got %0d", want.timer_running,
               got.timer_running);
        errors++;
      end
      if (got.timer_restart !== want.timer_restart) begin
        $error("timer_restart: expected %0d, got %0d", want.timer_restart,
               got.timer_restart);
        errors++;
      end
      if (got.duty_value !== want.duty_value) begin
        $error("duty_value: expected %0d, got %0d", want.duty_value, got.duty_value);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cmcd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cmcd_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [cmcd_pkg::REG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  console_mirror_board sb;
  bit gaps_on = 1'b1;
  bit done = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_words = 0;

  console_mirror_and_command_decoder_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // result side: check, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_word(out_data);
      out_stall <= gaps_on && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    if (rst || done || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic cmcd_pkg::in_item_t word_of(logic [1:0] action, logic [7:0] rx,
                                                 logic row, logic [3:0] col,
                                                 logic [7:0] ch);
    cmcd_pkg::in_item_t w;
    w.action = action;
    w.rx_byte = rx;
    w.cell_row = row;
    w.cell_col = col;
    w.cell_char = ch;
    return w;
  endfunction

  function automatic cmcd_pkg::in_item_t random_word();
    cmcd_pkg::in_item_t w;
    int unsigned        pick;
    logic [7:0]         cmd;
    w = IN_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) w.action = cmcd_pkg::ACT_RX;
    else if (pick < 75) w.action = cmcd_pkg::ACT_TX;
    else if (pick < 95) w.action = cmcd_pkg::ACT_CELL;
    else w.action = ACT_NONE;
    // bias received bytes toward commands, half of them upper case
    if (w.action == cmcd_pkg::ACT_RX && $urandom_range(99) < 60) begin
      case ($urandom_range(4))
        0: cmd = cmcd_pkg::CMD_PAUSE;
        1: cmd = cmcd_pkg::CMD_RESTART;
        2: cmd = cmcd_pkg::CMD_CONT;
        3: cmd = cmcd_pkg::CMD_MORE;
        default: cmd = cmcd_pkg::CMD_LESS;
      endcase
      w.rx_byte = $urandom_range(1) ? cmd - cmcd_pkg::CASE_OFFSET : cmd;
    end
    return w;
  endfunction

  task automatic send_word(cmcd_pkg::in_item_t w);
    while (gaps_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.accept_word(w);
    sent_words++;
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.configure(idx, value);
    @(posedge clk);
  endtask

  task automatic setup(logic [7:0] h1, logic [7:0] h2, logic [7:0] h3,
                       logic [15:0] ceil_v, logic [15:0] floor_v, logic [15:0] start_v);
    write_reg(cmcd_pkg::REG_HOME_FIRST, {24'd0, h1});
    write_reg(cmcd_pkg::REG_HOME_SECOND, {24'd0, h2});
    write_reg(cmcd_pkg::REG_HOME_THIRD, {24'd0, h3});
    write_reg(cmcd_pkg::REG_DUTY_CEILING, {16'd0, ceil_v});
    write_reg(cmcd_pkg::REG_DUTY_FLOOR, {16'd0, floor_v});
    write_reg(cmcd_pkg::REG_DUTY_START, {16'd0, start_v});
  endtask

  task automatic send_random(int count);
    repeat (count) send_word(random_word());
  endtask

  initial begin
    logic [15:0] start_v;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // home bytes at reset values, then cell writes at the corners
    repeat (3) send_word(word_of(cmcd_pkg::ACT_TX, 8'h00, 1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_CELL, 8'hff, 1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_CELL, 8'h00, 1'b0, 4'd15, 8'hff));
    send_word(word_of(cmcd_pkg::ACT_CELL, 8'h5a, 1'b1, 4'd0, 8'ha5));
    // every command in both cases; duty starts at zero so the last decrease holds
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_CONT, 1'b1, 4'd15, 8'hff));
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_CONT - cmcd_pkg::CASE_OFFSET,
                      1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_PAUSE, 1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_PAUSE - cmcd_pkg::CASE_OFFSET,
                      1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_RESTART, 1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_RESTART - cmcd_pkg::CASE_OFFSET,
                      1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_MORE, 1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_MORE - cmcd_pkg::CASE_OFFSET,
                      1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_LESS, 1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_RX, cmcd_pkg::CMD_LESS - cmcd_pkg::CASE_OFFSET,
                      1'b0, 4'd0, 8'h00));
    send_word(word_of(cmcd_pkg::ACT_RX, 8'h00, 1'b1, 4'd15, 8'hff));
    send_word(word_of(cmcd_pkg::ACT_RX, 8'hff, 1'b0, 4'd0, 8'h00));
    send_word(word_of(ACT_NONE, 8'hff, 1'b1, 4'd15, 8'hff));
    repeat (3) send_word(word_of(cmcd_pkg::ACT_TX, 8'h00, 1'b0, 4'd0, 8'h00));
    send_random(380);
    drain();

    // tight duty window, extreme home bytes
    setup(8'h00, 8'hff, 8'h48, 16'd100, 16'd50, 16'd75);
    send_random(350);
    drain();

    // nothing may move: ceiling at zero, floor and start at the top
    setup(8'hff, 8'h00, 8'hff, 16'd0, 16'd65535, 16'd65535);
    send_random(300);
    drain();

    // start below one step, no idling on either side for this stretch
    gaps_on = 1'b0;
    setup(8'h1b, 8'h5b, 8'h00, 16'd65535, 16'd0, 16'd3);
    send_random(300);
    drain();
    gaps_on = 1'b1;

    start_v = 16'($urandom_range(64000, 1000));
    setup(8'($urandom), 8'($urandom), 8'($urandom), 16'(start_v + $urandom_range(300)),
          16'(start_v - $urandom_range(300)), start_v);
    send_random(400);
    drain();

    done = 1'b1;
    $display("Sent %0d words, checked %0d results, %0d frame bytes.",
             sent_words, sb.words_checked, sb.frame_bytes);
    $display("Duty commands: %0d applied, %0d held at a limit.",
             sb.duty_moves, sb.duty_blocked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: console_mirror_and_command_decoder_unit.f
rtl/core/cmcd_pkg.sv
rtl/core/cmcd_ram.sv
rtl/core/cmcd_cfg.sv
rtl/core/cmcd_cmd.sv
rtl/core/console_mirror_and_command_decoder_unit.sv
bench/console_mirror_and_command_decoder_unit_test.sv
